/* design/msc_pkg.sv */
// Shared types and constants for the masked signature scan capture block.
package msc_pkg;

    localparam int PATTERN_BYTES_DEF = 16;
    localparam int WINDOW_BYTES_DEF  = 24;

    // The pattern registers hold sixteen bytes whatever the parameters say.
    localparam int PATTERN_REG_BYTES = 16;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int VALUE_W           = 64;
    // A captured value is accepted only when it lies below 2**29.
    localparam int VALUE_LIMIT_LOG2  = 29;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW      = 3'd0,
        REG_PATTERN_HIGH     = 3'd1,
        REG_CARE_MASK        = 3'd2,
        REG_PATTERN_LENGTH   = 3'd3,
        REG_CAPTURE_POSITION = 3'd4,
        REG_CAPTURE_SIZE     = 3'd5
    } cfg_reg_t;

    localparam logic [4:0] PATTERN_LENGTH_RST = 5'd1;
    localparam logic [3:0] CAPTURE_SIZE_RST   = 4'd4;

endpackage

/* design/masked_signature_scan_capture.sv */
// Top level of the masked signature scan capture block.
// A result passes the stage register, then the output register, before the master side sees it.
// Throughput: one byte per cycle when not stalled; compare and capture fit in a single stage.
// While a result waits on the master side, one further byte is still taken in.
// Reset is synchronous and active low; it empties the pipeline and restores the registers.
// A last beat clears the byte count and the match flag once its result has been formed.
module masked_signature_scan_capture #(
    parameter int PATTERN_BYTES = msc_pkg::PATTERN_BYTES_DEF,
    parameter int WINDOW_BYTES  = msc_pkg::WINDOW_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,    // data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [msc_pkg::VALUE_W-1:0]       m_tdata,    // captured_value
    output logic                              m_tuser,    // found
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import msc_pkg::*;

    localparam int LEN_MAX = (PATTERN_BYTES < PATTERN_REG_BYTES) ? PATTERN_BYTES
                                                                 : PATTERN_REG_BYTES;
    localparam int IDX_W   = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
    localparam int CNT_W   = $clog2(WINDOW_BYTES + 1);

    logic [63:0]        pattern_low_reg;
    logic [63:0]        pattern_high_reg;
    logic [15:0]        care_mask_reg;
    logic [4:0]         pattern_length_reg;
    logic [3:0]         capture_position_reg;
    logic [3:0]         capture_size_reg;

    logic [7:0]         window_reg [WINDOW_BYTES];
    logic [CNT_W-1:0]   seen_reg;
    logic [CNT_W-1:0]   seen_next;
    logic               match_done_reg;
    logic               match_done_next;
    logic               stage_valid_reg;
    logic               stage_last_reg;

    logic               out_valid_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] value_reg;

    logic               s_accept;
    logic               stage_move;
    logic               block_clear;
    logic               hit_ok;
    logic               stage_result;
    logic [VALUE_W-1:0] capture_value;
    logic [127:0]       pattern_bytes;

    assign cfg_ready     = 1'b1;
    assign pattern_bytes = {pattern_high_reg, pattern_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg      <= '0;
            pattern_high_reg     <= '0;
            care_mask_reg        <= '0;
            pattern_length_reg   <= PATTERN_LENGTH_RST;
            capture_position_reg <= '0;
            capture_size_reg     <= CAPTURE_SIZE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PATTERN_LOW:      pattern_low_reg      <= cfg_data;
                REG_PATTERN_HIGH:     pattern_high_reg     <= cfg_data;
                REG_CARE_MASK:        care_mask_reg        <= cfg_data[15:0];
                REG_PATTERN_LENGTH:   pattern_length_reg   <= cfg_data[4:0];
                REG_CAPTURE_POSITION: capture_position_reg <= cfg_data[3:0];
                REG_CAPTURE_SIZE:     capture_size_reg     <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign stage_move  = stage_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !stage_valid_reg || stage_move;
    assign s_accept    = s_tvalid && s_tready;
    assign block_clear = stage_move && stage_last_reg;

    // The window needs no reset: only bytes of the current block are ever compared.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            window_reg[0] <= s_tdata;
            for (int i = 1; i < WINDOW_BYTES; i++) begin
                window_reg[i] <= window_reg[i-1];
            end
        end
    end

    always_comb begin
        logic [CNT_W-1:0] base;
        base      = block_clear ? '0 : seen_reg;
        seen_next = base;
        if (s_accept && (32'(base) < WINDOW_BYTES)) begin
            seen_next = base + CNT_W'(1);
        end
        match_done_next = block_clear ? 1'b0
                                      : (match_done_reg || (stage_move && stage_result && hit_ok));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg        <= '0;
            match_done_reg  <= 1'b0;
            stage_valid_reg <= 1'b0;
            stage_last_reg  <= 1'b0;
        end else begin
            seen_reg       <= seen_next;
            match_done_reg <= match_done_next;
            if (s_accept) begin
                stage_valid_reg <= 1'b1;
                stage_last_reg  <= s_tlast;
            end else if (stage_move) begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    // Window compare and capture for the beat held in the stage.
    always_comb begin
        int  len;
        int  width;
        int  need;
        int  idx;
        logic [7:0] win_byte;
        logic match;

        len = int'(pattern_length_reg);
        if (len == 0) len = 1;
        if (len > LEN_MAX) len = LEN_MAX;

        unique case (capture_size_reg) inside
            4'd1:          width = 1;
            4'd2:          width = 2;
            [4'd8:4'd15]:  width = 8;
            default:       width = 4;
        endcase

        need = int'(capture_position_reg) + width;
        if (need < len) need = len;

        match = (need <= WINDOW_BYTES) && (int'(seen_reg) >= need);
        for (int k = 0; k < LEN_MAX; k++) begin
            idx      = need - 1 - k;
            win_byte = (idx >= 0 && idx < WINDOW_BYTES) ? window_reg[IDX_W'(idx)] : 8'h00;
            if (k < len && care_mask_reg[k] && win_byte != pattern_bytes[8*k +: 8]) begin
                match = 1'b0;
            end
        end

        capture_value = '0;
        for (int j = 0; j < 8; j++) begin
            idx      = need - 1 - int'(capture_position_reg) - j;
            win_byte = (idx >= 0 && idx < WINDOW_BYTES) ? window_reg[IDX_W'(idx)] : 8'h00;
            if (j < width) begin
                capture_value[8*j +: 8] = win_byte;
            end
        end

        hit_ok       = match && (capture_value[VALUE_W-1:VALUE_LIMIT_LOG2] == '0);
        stage_result = !match_done_reg && (hit_ok || stage_last_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stage_move && stage_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_move && stage_result) begin
            found_reg <= hit_ok;
            value_reg <= hit_ok ? capture_value : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = found_reg;

endmodule

/* design/msc_checker.sv */
// Port-level checker for the masked signature scan capture block, with its bind.
module msc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [msc_pkg::VALUE_W-1:0]       m_tdata,
    input logic                              m_tuser
);
    import msc_pkg::*;

    // A result beat that is held back keeps its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result beat changed.");

    // A block that ends without a match reports a zero value.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("Result without a match carries a non-zero value.");

    // An accepted match always lies below the value limit.
    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[VALUE_W-1:VALUE_LIMIT_LOG2] == '0)
        else $error("Reported value is above the limit.");

    // Reset leaves the master side empty.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result beat offered straight after reset.");

endmodule

bind masked_signature_scan_capture msc_checker u_msc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
